// ===== rtl/mvra_pkg.sv =====
// ============================================================================
// MSI vector run allocator package
// Sizes, status codes and request/response types shared by the block.
// ============================================================================
package mvra_pkg;

    localparam int MAX_VECTORS       = 64;
    localparam int MAX_DEVICES       = 16;
    localparam int EVENTS_PER_DEVICE = 32;

    localparam int VEC_W  = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int END_W  = $clog2(MAX_VECTORS + 1);
    localparam int SLOT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

    localparam int ID_W   = 16;
    localparam int CNT_W  = 7;
    localparam int VNUM_W = 16;
    localparam int EV_W   = 5;
    localparam int VRAM_W = ID_W + EV_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CNT = 2'd1;
    localparam logic [1:0] ST_NO_SLOT = 2'd2;
    localparam logic [1:0] ST_NO_RUN  = 2'd3;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ID_W-1:0]   source_id;
        logic [CNT_W-1:0]  count;
        logic [VNUM_W-1:0] start_vector;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [VNUM_W-1:0] first_vector;
        logic              released;
        logic [ID_W-1:0]   released_requester;
        logic [EV_W-1:0]   released_event;
        logic              last;
    } t_rsp;

endpackage

// ===== rtl/mvra_ifs.sv =====
// ============================================================================
// MSI vector run allocator channels
// Valid/ready channels carrying requests into and responses out of the block.
// ============================================================================
interface mvra_req_if;
    import mvra_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mvra_rsp_if;
    import mvra_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/mvra_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module mvra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/msi_vector_run_allocator_top.sv =====
// ============================================================================
// MSI vector run allocator
// First-fit allocator for contiguous runs of interrupt vectors per device.
// ============================================================================
// Usage:
// Requests arrive on i_req (valid/ready). An allocate request asks for a run
// of count vectors for source_id; a free request releases up to count
// vectors starting at start_vector. Responses leave on o_rsp (valid/ready).
// An allocate request always yields exactly one response. A free request
// yields one response per released vector, the final one marked last, or a
// single empty response marked last when nothing was in use.
// The block handles one request at a time; i_req.ready is high only while it
// is idle. An allocate checks the count, reads the device slots in turn until
// it finds the requester (up to MAX_DEVICES), scans vector positions for a
// free run (up to MAX_VECTORS), records the run one vector at a time, then
// loads the response register. The slot table and the owner/event table sit in
// single-read-port RAMs, so slots and vectors are read one at a time. A free
// walks the vectors of its window one by one and reads the owner of each
// released vector; when nothing is released, it loads the empty response.
// A response waits in an output register; the block returns to idle and takes
// the next request while it waits, but a free walk holds until the receiver
// takes each response. Reset clears the in-use and slot-valid bits and the
// vector_base register; no clearing pass is needed afterwards.
// ============================================================================
module msi_vector_run_allocator_top
    import mvra_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    mvra_req_if.sink          i_req,
    mvra_rsp_if.source        o_rsp,
    input  logic              i_cfg_we,
    input  logic [VNUM_W-1:0] i_cfg_wdata
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_SLOT     = 4'd2;
    localparam logic [3:0] S_SLOT_CHK = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_MARK     = 4'd5;
    localparam logic [3:0] S_WALK     = 4'd6;
    localparam logic [3:0] S_FREE_RD  = 4'd7;
    localparam logic [3:0] S_EMIT     = 4'd8;

    // Control state.
    logic [3:0]             r_state, n_state;
    logic [MAX_VECTORS-1:0] r_in_use, n_in_use;
    logic [MAX_DEVICES-1:0] r_slot_valid, n_slot_valid;
    logic                   r_out_valid, n_out_valid;
    logic [VNUM_W-1:0]      r_vector_base;

    // Working registers of the current request.
    t_req              r_req, n_req;
    logic [SLOT_W-1:0] r_sidx, n_sidx;
    logic              r_free_found, n_free_found;
    logic [SLOT_W-1:0] r_free_slot, n_free_slot;
    logic [VEC_W-1:0]  r_vidx, n_vidx;
    logic [CNT_W-1:0]  r_run, n_run;
    logic [CNT_W-1:0]  r_ev, n_ev;
    logic [VEC_W-1:0]  r_base, n_base;
    logic [END_W-1:0]  r_end, n_end;
    logic              r_last, n_last;
    t_rsp              r_pend, n_pend;
    t_rsp              r_out, n_out;

    // RAM ports.
    logic              slot_we;
    logic [SLOT_W-1:0] slot_waddr;
    logic [ID_W-1:0]   slot_rdata;
    logic              vec_we;
    logic              vec_re;
    logic [VRAM_W-1:0] vec_rdata;

    logic                   out_free;
    logic                   slot_hit;
    logic                   nf_found;
    logic [SLOT_W-1:0]      nf_slot;
    logic [CNT_W:0]         base_calc;
    logic [VNUM_W:0]        free_diff;
    logic [VNUM_W:0]        free_end;
    logic                   walk_at_end;
    logic [MAX_VECTORS-1:0] later_mask;

    assign out_free = !r_out_valid || o_rsp.ready;

    // Slot table: requester of each claimed device slot.
    mvra_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_DEVICES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (r_req.source_id),
        .i_re    (r_state == S_SLOT),
        .i_raddr (r_sidx),
        .o_rdata (slot_rdata)
    );

    // Vector table: owner requester and event number of each vector.
    mvra_ram #(
        .WIDTH (VRAM_W),
        .DEPTH (MAX_VECTORS)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (r_vidx),
        .i_wdata ({r_req.source_id, r_ev[EV_W-1:0]}),
        .i_re    (vec_re),
        .i_raddr (r_vidx),
        .o_rdata (vec_rdata)
    );

    // Slot search helpers: a hit on a valid slot wins over the lowest free one.
    assign slot_hit = r_slot_valid[r_sidx] && (slot_rdata == r_req.source_id);
    assign nf_found = r_free_found || !r_slot_valid[r_sidx];
    assign nf_slot  = r_free_found ? r_free_slot : r_sidx;

    // Lowest index of a run that ends at the current scan position.
    assign base_calc = (CNT_W+1)'(r_vidx) + (CNT_W+1)'(1) - (CNT_W+1)'(r_req.count);

    // Free window: offset of start_vector and its end, before clipping.
    assign free_diff = {1'b0, r_req.start_vector} - {1'b0, r_vector_base};
    assign free_end  = {1'b0, free_diff[VNUM_W-1:0]} + (VNUM_W+1)'(r_req.count);

    assign walk_at_end = ((END_W'(r_vidx) + END_W'(1)) == r_end);

    // Vectors still ahead in the free window; none in use means this is last.
    always_comb begin
        for (int i = 0; i < MAX_VECTORS; i++) begin
            later_mask[i] = (VEC_W'(i) > r_vidx) && (END_W'(i) < r_end);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_in_use     = r_in_use;
        n_slot_valid = r_slot_valid;
        n_out_valid  = r_out_valid;
        n_req        = r_req;
        n_sidx       = r_sidx;
        n_free_found = r_free_found;
        n_free_slot  = r_free_slot;
        n_vidx       = r_vidx;
        n_run        = r_run;
        n_ev         = r_ev;
        n_base       = r_base;
        n_end        = r_end;
        n_last       = r_last;
        n_pend       = r_pend;
        n_out        = r_out;
        slot_we      = 1'b0;
        slot_waddr   = r_free_slot;
        vec_we       = 1'b0;
        vec_re       = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req   = i_req.payload;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_pend = '{status: ST_OK, first_vector: '0, released: 1'b0,
                           released_requester: '0, released_event: '0, last: 1'b1};
                n_vidx = '0;
                n_run  = '0;
                if (r_req.req_type == REQ_ALLOC) begin
                    if (r_req.count == '0 || r_req.count > CNT_W'(EVENTS_PER_DEVICE)) begin
                        n_pend.status = ST_BAD_CNT;
                        n_state       = S_EMIT;
                    end else begin
                        n_sidx       = '0;
                        n_free_found = 1'b0;
                        n_free_slot  = '0;
                        n_state      = S_SLOT;
                    end
                end else begin
                    // Below the base, beyond the range or an empty count: nothing to free.
                    if (free_diff[VNUM_W] || r_req.count == '0 ||
                        free_diff[VNUM_W-1:0] >= VNUM_W'(MAX_VECTORS)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_vidx  = free_diff[VEC_W-1:0];
                        n_end   = (free_end > (VNUM_W+1)'(MAX_VECTORS)) ?
                                  END_W'(MAX_VECTORS) : free_end[END_W-1:0];
                        n_state = S_WALK;
                    end
                end
            end
            S_SLOT: begin
                n_state = S_SLOT_CHK;
            end
            S_SLOT_CHK: begin
                if (slot_hit) begin
                    n_state = S_SCAN;
                end else if (r_sidx == SLOT_W'(MAX_DEVICES - 1)) begin
                    if (nf_found) begin
                        slot_we               = 1'b1;
                        slot_waddr            = nf_slot;
                        n_slot_valid[nf_slot] = 1'b1;
                        n_state               = S_SCAN;
                    end else begin
                        n_pend.status = ST_NO_SLOT;
                        n_state       = S_EMIT;
                    end
                end else begin
                    n_sidx       = r_sidx + SLOT_W'(1);
                    n_free_found = nf_found;
                    n_free_slot  = nf_slot;
                    n_state      = S_SLOT;
                end
            end
            S_SCAN: begin
                if (r_in_use[r_vidx]) begin
                    n_run = '0;
                end else begin
                    n_run = r_run + CNT_W'(1);
                end
                if (!r_in_use[r_vidx] && (r_run + CNT_W'(1) == r_req.count)) begin
                    n_base  = base_calc[VEC_W-1:0];
                    n_vidx  = base_calc[VEC_W-1:0];
                    n_ev    = '0;
                    n_state = S_MARK;
                end else if (r_vidx == VEC_W'(MAX_VECTORS - 1)) begin
                    n_pend.status = ST_NO_RUN;
                    n_state       = S_EMIT;
                end else begin
                    n_vidx = r_vidx + VEC_W'(1);
                end
            end
            S_MARK: begin
                vec_we           = 1'b1;
                n_in_use[r_vidx] = 1'b1;
                n_ev             = r_ev + CNT_W'(1);
                if (r_ev + CNT_W'(1) == r_req.count) begin
                    n_pend.first_vector = r_vector_base + VNUM_W'(r_base);
                    n_state             = S_EMIT;
                end else begin
                    n_vidx = r_vidx + VEC_W'(1);
                end
            end
            S_WALK: begin
                if (r_in_use[r_vidx]) begin
                    vec_re           = 1'b1;
                    n_in_use[r_vidx] = 1'b0;
                    n_last           = ~|(r_in_use & later_mask);
                    n_state          = S_FREE_RD;
                end else if (walk_at_end) begin
                    n_state = S_EMIT;
                end else begin
                    n_vidx = r_vidx + VEC_W'(1);
                end
            end
            S_FREE_RD: begin
                // The owner read stays in the RAM output register until sent.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{status: ST_OK, first_vector: '0, released: 1'b1,
                              released_requester: vec_rdata[VRAM_W-1:EV_W],
                              released_event: vec_rdata[EV_W-1:0], last: r_last};
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_vidx  = r_vidx + VEC_W'(1);
                        n_state = S_WALK;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_in_use      <= '0;
            r_slot_valid  <= '0;
            r_out_valid   <= 1'b0;
            r_vector_base <= '0;
        end else begin
            r_state      <= n_state;
            r_in_use     <= n_in_use;
            r_slot_valid <= n_slot_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_vector_base <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_sidx       <= n_sidx;
        r_free_found <= n_free_found;
        r_free_slot  <= n_free_slot;
        r_vidx       <= n_vidx;
        r_run        <= n_run;
        r_ev         <= n_ev;
        r_base       <= n_base;
        r_end        <= n_end;
        r_last       <= n_last;
        r_pend       <= n_pend;
        r_out        <= n_out;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

// ===== rtl/mvra_checker.sv =====
// ============================================================================
// MSI vector run allocator checker
// Port-level assertions on the allocator, attached to the top level by bind.
// ============================================================================
module mvra_checker
    import mvra_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp
);

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp))
        else $error("response changed while stalled");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in progress");

    // A released vector is always reported with an ok status and no base.
    a_release_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.released |-> i_rsp.status == ST_OK && i_rsp.first_vector == '0)
        else $error("malformed release response");

    // Only a free walk produces more than one response.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp.released |-> i_rsp.last)
        else $error("non-release response not marked last");

    // A failed allocate reports no vector.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp.status != ST_OK |-> i_rsp.first_vector == '0 && !i_rsp.released)
        else $error("failed allocate reports a vector");

endmodule

bind msi_vector_run_allocator_top mvra_checker u_mvra_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp       (o_rsp.payload)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// MSI vector run allocator testbench
// Drives allocate and free requests through the request channel, predicts
// every response from a behavioral copy of the vector map and slot table,
// and compares each response field by field as it leaves the block.
// ============================================================================
module tb_top
    import mvra_pkg::*;
();

    // Generous cap on the run. The slowest legal run (every free releasing
    // 64 vectors against a stalling receiver) stays well below this.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Cycles allowed after the last response before the block is treated as
    // idle; this covers the longest allocate scan with margin.
    localparam int SETTLE_CYCLES = 200;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [VNUM_W-1:0] cfg_wdata = '0;

    mvra_req_if req_ch ();
    mvra_rsp_if rsp_ch ();

    msi_vector_run_allocator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral copy of the allocator state. It is updated when a request
    // is accepted, which matches the block since it serves one request at a
    // time and in order.
    // ------------------------------------------------------------------------
    logic [VNUM_W-1:0] base_model = '0;
    bit                vec_busy  [MAX_VECTORS];
    logic [ID_W-1:0]   vec_owner [MAX_VECTORS];
    logic [EV_W-1:0]   vec_event [MAX_VECTORS];
    bit                slot_used [MAX_DEVICES];
    logic [ID_W-1:0]   slot_id   [MAX_DEVICES];

    t_req queued_requests[$];   // requests waiting for the driver
    t_rsp owed_responses[$];    // responses the block still has to produce

    logic [ID_W-1:0] device_ids[MAX_DEVICES];   // requesters that get slots
    int  mismatches = 0;
    int  cycle_count = 0;
    bit  no_gaps = 1'b0;        // set for the stretch with no idling at all

    // Works out the responses of one accepted request and updates the map.
    function automatic void apply_request(t_req r);
        t_rsp rsp;
        int   run_at;
        int   idx;
        int   left;
        int   n;
        bit   fits;
        bit   placed;
        rsp = '0;
        rsp.last = 1'b1;
        if (r.req_type == REQ_ALLOC) begin
            if (r.count == 0 || int'(r.count) > EVENTS_PER_DEVICE) begin
                rsp.status = ST_BAD_CNT;
            end else begin
                // A known requester keeps its slot; a new one takes the
                // lowest free slot, and keeps it even if no run is found.
                placed = 1'b0;
                for (int s = 0; s < MAX_DEVICES; s++)
                    if (slot_used[s] && slot_id[s] == r.source_id)
                        placed = 1'b1;
                for (int s = 0; s < MAX_DEVICES && !placed; s++) begin
                    if (!slot_used[s]) begin
                        slot_used[s] = 1'b1;
                        slot_id[s]   = r.source_id;
                        placed       = 1'b1;
                    end
                end
                if (!placed) begin
                    rsp.status = ST_NO_SLOT;
                end else begin
                    run_at = -1;
                    for (int b = 0; b + int'(r.count) <= MAX_VECTORS; b++) begin
                        fits = 1'b1;
                        for (int i = 0; i < int'(r.count); i++)
                            if (vec_busy[b + i])
                                fits = 1'b0;
                        if (fits && run_at < 0)
                            run_at = b;
                    end
                    if (run_at < 0) begin
                        rsp.status = ST_NO_RUN;
                    end else begin
                        for (int i = 0; i < int'(r.count); i++) begin
                            vec_busy[run_at + i]  = 1'b1;
                            vec_owner[run_at + i] = r.source_id;
                            vec_event[run_at + i] = EV_W'(i);
                        end
                        rsp.status       = ST_OK;
                        rsp.first_vector = base_model + VNUM_W'(run_at);
                    end
                end
            end
            owed_responses.push_back(rsp);
        end else begin
            n = 0;
            if (r.start_vector >= base_model) begin
                idx  = int'(r.start_vector) - int'(base_model);
                left = int'(r.count);
                while (left > 0 && idx < MAX_VECTORS) begin
                    if (vec_busy[idx]) begin
                        rsp                    = '0;
                        rsp.released           = 1'b1;
                        rsp.released_requester = vec_owner[idx];
                        rsp.released_event     = vec_event[idx];
                        owed_responses.push_back(rsp);
                        vec_busy[idx] = 1'b0;
                        n++;
                    end
                    idx++;
                    left--;
                end
            end
            if (n == 0)
                owed_responses.push_back(rsp);
            else
                owed_responses[owed_responses.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want,
                                        logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // Roughly one cycle in five is an idle cycle on either side.
    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(0, 99) < 20);
    endfunction

    // ------------------------------------------------------------------------
    // Request driver. A request stays on the channel until the block takes
    // it; the next one is loaded in the same edge unless a gap is rolled.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : drive_requests
        t_req next_req;
        logic next_valid;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            next_valid = req_ch.valid;
            next_req   = req_ch.payload;
            if (req_ch.valid && req_ch.ready) begin
                apply_request(req_ch.payload);
                next_valid = 1'b0;
            end
            if (!next_valid && queued_requests.size() != 0 && !take_gap()) begin
                next_req   = queued_requests.pop_front();
                next_valid = 1'b1;
            end
            req_ch.valid   <= next_valid;
            req_ch.payload <= next_req;
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Every accepted response is matched against the
    // oldest owed one; ready drops at random to stall the free walk.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : check_responses
        t_rsp want;
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (owed_responses.size() == 0) begin
                    $error("response with none expected: status %0d last %0d",
                           rsp_ch.payload.status, rsp_ch.payload.last);
                    mismatches++;
                end else begin
                    want = owed_responses.pop_front();
                    check_field("status", 32'(want.status),
                                32'(rsp_ch.payload.status));
                    check_field("first_vector", 32'(want.first_vector),
                                32'(rsp_ch.payload.first_vector));
                    check_field("released", 32'(want.released),
                                32'(rsp_ch.payload.released));
                    check_field("released_requester", 32'(want.released_requester),
                                32'(rsp_ch.payload.released_requester));
                    check_field("released_event", 32'(want.released_event),
                                32'(rsp_ch.payload.released_event));
                    check_field("last", 32'(want.last), 32'(rsp_ch.payload.last));
                end
            end
            rsp_ch.ready <= !take_gap();
        end
    end

    // Hard stop if the block hangs or loses a response.
    always @(posedge clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_alloc(logic [ID_W-1:0] id, int cnt);
        t_req r;
        r.req_type     = REQ_ALLOC;
        r.source_id    = id;
        r.count        = CNT_W'(cnt);
        r.start_vector = VNUM_W'($urandom());   // ignored on allocate
        queued_requests.push_back(r);
    endtask

    task automatic queue_free(logic [VNUM_W-1:0] start, int cnt);
        t_req r;
        r.req_type     = REQ_FREE;
        r.source_id    = ID_W'($urandom());     // ignored on free
        r.count        = CNT_W'(cnt);
        r.start_vector = start;
        queued_requests.push_back(r);
    endtask

    // Mostly well-formed traffic from the known requesters: small runs so
    // allocations keep succeeding, and frees aimed inside the vector range.
    // A minority is noise: bad counts, unknown requesters, wild start vectors.
    task automatic queue_random(int n_items);
        int               roll;
        int               cnt;
        logic [ID_W-1:0]  id;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                if ($urandom_range(0, 19) == 0)
                    id = ID_W'($urandom());
                else
                    id = device_ids[$urandom_range(0, MAX_DEVICES - 1)];
                if ($urandom_range(0, 9) == 0)
                    cnt = $urandom_range(0, 64);
                else if ($urandom_range(0, 3) == 0)
                    cnt = $urandom_range(1, EVENTS_PER_DEVICE);
                else
                    cnt = $urandom_range(1, 8);
                queue_alloc(id, cnt);
            end else if (roll < 90) begin
                if ($urandom_range(0, 7) == 0)
                    queue_free(base_model, MAX_VECTORS);
                else
                    queue_free(base_model + VNUM_W'($urandom_range(0, MAX_VECTORS - 1)),
                               $urandom_range(0, 7) == 0 ? 64 : $urandom_range(1, 16));
            end else begin
                queue_free(VNUM_W'($urandom()), $urandom_range(0, 64));
            end
        end
    endtask

    // Holds the sender until every request has gone and every owed response
    // has come back, then lets the block settle.
    task automatic wait_for_drain();
        while (queued_requests.size() != 0 || req_ch.valid ||
               owed_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_vector_base(logic [VNUM_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        base_model = value;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        // Sixteen distinct requesters fill the slot table exactly. The all
        // ones and all zeros IDs exercise every requester bit; the rest are
        // kept distinct through their upper byte.
        device_ids[0] = 16'hFFFF;
        device_ids[1] = 16'h0000;
        for (int k = 2; k < MAX_DEVICES; k++)
            device_ids[k] = {8'(k), 8'($urandom())};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: vector base at zero.
        write_vector_base(16'h0000);

        // Counts outside 1..32 are rejected and claim no slot.
        queue_alloc(device_ids[0], 0);
        queue_alloc(device_ids[0], EVENTS_PER_DEVICE + 1);
        queue_alloc(device_ids[0], 64);
        // Largest run, then a single vector right behind it.
        queue_alloc(device_ids[0], EVENTS_PER_DEVICE);
        queue_alloc(device_ids[1], 1);
        // Only 31 vectors remain, so a run of 32 fails while the slot stays.
        queue_alloc(device_ids[1], EVENTS_PER_DEVICE);
        queue_alloc(device_ids[1], EVENTS_PER_DEVICE - 1);
        // Map is full: a new requester takes a slot but finds no run.
        queue_alloc(device_ids[2], 1);
        // Free the whole range: 64 responses, the most one request can cause.
        queue_free(16'h0000, MAX_VECTORS);
        // Nothing left to free, then a start far beyond the range.
        queue_free(16'h0000, 1);
        queue_free(16'hFFFF, 64);
        // Fill the remaining slots; one more requester finds no slot.
        for (int k = 3; k < MAX_DEVICES; k++)
            queue_alloc(device_ids[k], 1);
        queue_alloc(16'hABCD, 1);
        // A free over a partly used stretch skips the unused vectors.
        queue_free(16'h0005, 20);
        queue_random(60);
        wait_for_drain();

        // Phase two: highest vector base, so first_vector reaches the top of
        // the 16-bit number space.
        write_vector_base(16'hFFC0);
        queue_free(16'd100, 64);            // start below the base frees nothing
        queue_alloc(device_ids[4], EVENTS_PER_DEVICE);
        queue_free(16'hFFFF, 64);           // last vector of the range only
        queue_random(50);
        wait_for_drain();

        // Phase three: a random base, run with no idle cycles on either side.
        write_vector_base(VNUM_W'($urandom_range(64, 16'hFF80)));
        no_gaps = 1'b1;
        queue_random(50);
        wait_for_drain();
        no_gaps = 1'b0;

        // Phase four: a small base with all low bits set.
        write_vector_base(16'h003F);
        queue_random(20);
        wait_for_drain();

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== msi_vector_run_allocator_top.f =====
rtl/mvra_pkg.sv
rtl/mvra_ifs.sv
rtl/mvra_ram.sv
rtl/msi_vector_run_allocator_top.sv
rtl/mvra_checker.sv
tb/tb_top.sv
